[src/etbf_pkg.sv]
// shared types and constants of the edge table shortest path router
package etbf_pkg;

    localparam int NODES_DEF  = 8;
    localparam int EDGES_DEF  = 64;
    localparam int NODE_W     = 3;
    localparam int COST_W     = 10;
    localparam int DIST_W     = 14;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [DIST_W-1:0] UNREACH = 14'd10000;

    typedef logic [NODE_W-1:0] node_t;

    typedef struct packed {
        node_t             start_node;
        node_t             end_node;
        logic [COST_W-1:0] cost;
    } edge_word_t;

    typedef struct packed {
        logic              pred_ok;
        node_t             pred;
        logic [DIST_W-1:0] dist_val;
    } node_word_t;

    localparam node_word_t NODE_RESET = '{pred_ok: 1'b0, pred: '0, dist_val: UNREACH};

    typedef struct packed {
        node_t      node_index;
        node_word_t entry;
        logic       table_full;
        logic       last_entry;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_APPEND,
        ST_INIT,
        ST_RELAX,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

endpackage

[src/etbf_edge_mem.sv]
// edge table memory, one write and one registered read port
module etbf_edge_mem import etbf_pkg::*; #(
    parameter int  EDGES  = EDGES_DEF,
    localparam int EIDX_W = $clog2(EDGES)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [EIDX_W-1:0] waddr,
    input  edge_word_t        wdata,
    input  logic [EIDX_W-1:0] raddr,
    output edge_word_t        rdata
);

    edge_word_t edge_ram [EDGES];
    edge_word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            edge_ram[waddr] <= wdata;
        end
        rdata_reg <= edge_ram[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/etbf_node_mem.sv]
// node distance memory with two registered read ports and per entry valid bits
module etbf_node_mem import etbf_pkg::*; #(
    parameter int  NODES  = NODES_DEF,
    localparam int NIDX_W = $clog2(NODES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              we,
    input  logic [NIDX_W-1:0] waddr,
    input  node_word_t        wdata,
    input  logic [NIDX_W-1:0] raddr_a,
    input  logic [NIDX_W-1:0] raddr_b,
    output node_word_t        rdata_a,
    output node_word_t        rdata_b
);

    node_word_t       node_ram [NODES];
    logic [NODES-1:0] valid_reg;
    node_word_t       a_reg;
    node_word_t       b_reg;
    logic             va_reg;
    logic             vb_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            node_ram[waddr] <= wdata;
        end
        a_reg  <= node_ram[raddr_a];
        b_reg  <= node_ram[raddr_b];
        va_reg <= valid_reg[raddr_a];
        vb_reg <= valid_reg[raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata_a = va_reg ? a_reg : NODE_RESET;
    assign rdata_b = vb_reg ? b_reg : NODE_RESET;

endmodule

[src/etbf_ctrl.sv]
// sequencer: edge lookup and append, pipelined relaxation rounds, result beats
module etbf_ctrl import etbf_pkg::*; #(
    parameter int  NODES  = NODES_DEF,
    parameter int  EDGES  = EDGES_DEF,
    localparam int NIDX_W = $clog2(NODES),
    localparam int RND_W  = $clog2(NODES),
    localparam int EIDX_W = $clog2(EDGES),
    localparam int CNT_W  = $clog2(EDGES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  edge_word_t        s_edge,
    input  node_t             source,
    output logic              edge_we,
    output logic [EIDX_W-1:0] edge_waddr,
    output edge_word_t        edge_wdata,
    output logic [EIDX_W-1:0] edge_raddr,
    input  edge_word_t        edge_rdata,
    output logic              node_clear,
    output logic              node_we,
    output logic [NIDX_W-1:0] node_waddr,
    output node_word_t        node_wdata,
    output logic [NIDX_W-1:0] node_raddr_a,
    output logic [NIDX_W-1:0] node_raddr_b,
    input  node_word_t        node_rdata_a,
    input  node_word_t        node_rdata_b,
    output logic              m_valid,
    input  logic              m_ready,
    output result_t           m_result
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [NIDX_W-1:0] out_idx_reg, out_idx_next;
    edge_word_t        in_reg, in_next;
    logic              found_reg, found_next;
    logic              full_reg, full_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [EIDX_W-1:0] s1_idx_reg, s1_idx_next;
    logic              s2_valid_reg, s2_valid_next;
    node_t             s2_u_reg, s2_u_next;
    node_t             s2_v_reg, s2_v_next;
    logic [COST_W-1:0] s2_cost_reg, s2_cost_next;
    logic              fw_valid_reg, fw_valid_next;
    logic [NIDX_W-1:0] fw_addr_reg, fw_addr_next;
    node_word_t        fw_word_reg, fw_word_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_result_reg, m_result_next;

    logic              edge_ok;
    node_word_t        du;
    node_word_t        dv;
    logic [DIST_W:0]   cand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            fw_valid_reg <= fw_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        rnd_reg      <= rnd_next;
        out_idx_reg  <= out_idx_next;
        in_reg       <= in_next;
        found_reg    <= found_next;
        full_reg     <= full_next;
        s1_idx_reg   <= s1_idx_next;
        s2_u_reg     <= s2_u_next;
        s2_v_reg     <= s2_v_next;
        s2_cost_reg  <= s2_cost_next;
        fw_addr_reg  <= fw_addr_next;
        fw_word_reg  <= fw_word_next;
        m_result_reg <= m_result_next;
    end

    // relax stage: operands with forwarding of the write from the cycle before
    always_comb begin
        du = (fw_valid_reg && fw_addr_reg == NIDX_W'(s2_u_reg)) ? fw_word_reg : node_rdata_a;
        dv = (fw_valid_reg && fw_addr_reg == NIDX_W'(s2_v_reg)) ? fw_word_reg : node_rdata_b;
        cand = {1'b0, du.dist_val} + (DIST_W + 1)'(s2_cost_reg);
        edge_ok = (int'(edge_rdata.start_node) < NODES) && (int'(edge_rdata.end_node) < NODES);
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        rnd_next      = rnd_reg;
        out_idx_next  = out_idx_reg;
        in_next       = in_reg;
        found_next    = found_reg;
        full_next     = full_reg;
        s1_valid_next = 1'b0;
        s1_idx_next   = s1_idx_reg;
        s2_valid_next = 1'b0;
        s2_u_next     = edge_rdata.start_node;
        s2_v_next     = edge_rdata.end_node;
        s2_cost_next  = edge_rdata.cost;
        fw_valid_next = 1'b0;
        fw_addr_next  = fw_addr_reg;
        fw_word_next  = fw_word_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_result_next = m_result_reg;

        s_ready      = 1'b0;
        edge_we      = 1'b0;
        edge_waddr   = s1_idx_reg;
        edge_wdata   = in_reg;
        edge_raddr   = idx_reg[EIDX_W-1:0];
        node_clear   = 1'b0;
        node_we      = 1'b0;
        node_waddr   = NIDX_W'(s2_v_reg);
        node_wdata   = '{pred_ok: 1'b1, pred: s2_u_reg, dist_val: cand[DIST_W-1:0]};
        node_raddr_a = NIDX_W'(edge_rdata.start_node);
        node_raddr_b = NIDX_W'(edge_rdata.end_node);

        // lookup compare of the entry read last cycle
        if (s1_valid_reg && state_reg == ST_LOOKUP) begin
            if (edge_rdata.start_node == in_reg.start_node &&
                edge_rdata.end_node == in_reg.end_node) begin
                edge_we    = 1'b1;
                found_next = 1'b1;
            end
        end

        // relaxation issue of node reads
        if (s1_valid_reg && state_reg != ST_LOOKUP) begin
            s2_valid_next = edge_ok;
        end

        // relaxation compare and write back
        if (s2_valid_reg) begin
            if (du.dist_val != UNREACH && cand < {1'b0, dv.dist_val}) begin
                node_we       = 1'b1;
                fw_valid_next = 1'b1;
                fw_addr_next  = NIDX_W'(s2_v_reg);
                fw_word_next  = node_wdata;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next    = s_edge;
                    idx_next   = '0;
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (idx_reg < cnt_reg) begin
                    s1_valid_next = 1'b1;
                    s1_idx_next   = idx_reg[EIDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end else if (!s1_valid_reg) begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (!found_reg) begin
                    if (cnt_reg < CNT_W'(EDGES)) begin
                        edge_we    = 1'b1;
                        edge_waddr = cnt_reg[EIDX_W-1:0];
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end else begin
                        full_next = 1'b1;
                    end
                end
                state_next = ST_INIT;
            end
            ST_INIT: begin
                node_clear = 1'b1;
                if (int'(source) < NODES) begin
                    node_we    = 1'b1;
                    node_waddr = NIDX_W'(source);
                    node_wdata = '{pred_ok: 1'b0, pred: '0, dist_val: '0};
                end
                idx_next     = '0;
                rnd_next     = RND_W'(1);
                out_idx_next = '0;
                state_next   = (cnt_reg == '0) ? ST_OUT_RD : ST_RELAX;
            end
            ST_RELAX: begin
                s1_valid_next = 1'b1;
                if (idx_reg + CNT_W'(1) == cnt_reg) begin
                    idx_next = '0;
                    if (rnd_reg == RND_W'(NODES - 1)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        rnd_next = rnd_reg + RND_W'(1);
                    end
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg) begin
                    out_idx_next = '0;
                    state_next   = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                node_raddr_a = out_idx_reg;
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_OUT_LD;
                end
            end
            ST_OUT_LD: begin
                m_valid_next  = 1'b1;
                m_result_next = '{node_index: NODE_W'(out_idx_reg),
                                  entry:      node_rdata_a,
                                  table_full: full_reg,
                                  last_entry: out_idx_reg == NIDX_W'(NODES - 1)};
                if (out_idx_reg == NIDX_W'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    out_idx_next = out_idx_reg + NIDX_W'(1);
                    state_next   = ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

[src/edge_table_bellman_ford_router.sv]
// Edge table shortest path router. Each s_ transfer carries one directed edge; the block
// overwrites the cost of a stored edge with the same endpoints or appends it (a full table
// drops it and flags table_full), then recomputes shortest paths from source_node and sends
// NODES result transfers on m_, node 0 first, tlast on the last. The edge table has a single
// read port, so the lookup scans one edge a cycle and the relaxation pipeline handles one
// edge a cycle per round; each result beat goes through a node memory read (ST_OUT_RD, then
// ST_OUT_LD) and can be held by an m_tready stall. s_tready is high only between items.
// cfg_ready is always high.
module edge_table_bellman_ford_router import etbf_pkg::*; #(
    parameter int NODES = NODES_DEF,
    parameter int EDGES = EDGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // from_node, to_node, link_weight
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // node_index, distance, pred_node, prev_valid
    output logic                  m_tuser,   // table_full
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [NODE_W-1:0]     cfg_data   // source_node
);

    localparam int NIDX_W = $clog2(NODES);
    localparam int EIDX_W = $clog2(EDGES);

    node_t             source_reg;
    edge_word_t        s_edge;
    logic              edge_we;
    logic [EIDX_W-1:0] edge_waddr;
    edge_word_t        edge_wdata;
    logic [EIDX_W-1:0] edge_raddr;
    edge_word_t        edge_rdata;
    logic              node_clear;
    logic              node_we;
    logic [NIDX_W-1:0] node_waddr;
    node_word_t        node_wdata;
    logic [NIDX_W-1:0] node_raddr_a;
    logic [NIDX_W-1:0] node_raddr_b;
    node_word_t        node_rdata_a;
    node_word_t        node_rdata_b;
    result_t           result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_reg <= '0;
        end else if (cfg_valid) begin
            source_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    assign s_edge = '{start_node: s_tdata[2:0], end_node: s_tdata[5:3], cost: s_tdata[15:6]};

    etbf_edge_mem #(.EDGES(EDGES)) u_edge_mem (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    etbf_node_mem #(.NODES(NODES)) u_node_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (node_clear),
        .we      (node_we),
        .waddr   (node_waddr),
        .wdata   (node_wdata),
        .raddr_a (node_raddr_a),
        .raddr_b (node_raddr_b),
        .rdata_a (node_rdata_a),
        .rdata_b (node_rdata_b)
    );

    etbf_ctrl #(.NODES(NODES), .EDGES(EDGES)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_edge       (s_edge),
        .source       (source_reg),
        .edge_we      (edge_we),
        .edge_waddr   (edge_waddr),
        .edge_wdata   (edge_wdata),
        .edge_raddr   (edge_raddr),
        .edge_rdata   (edge_rdata),
        .node_clear   (node_clear),
        .node_we      (node_we),
        .node_waddr   (node_waddr),
        .node_wdata   (node_wdata),
        .node_raddr_a (node_raddr_a),
        .node_raddr_b (node_raddr_b),
        .node_rdata_a (node_rdata_a),
        .node_rdata_b (node_rdata_b),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_result     (result)
    );

    assign m_tdata = {3'b000, result.entry.pred_ok, result.entry.pred,
                      result.entry.dist_val, result.node_index};
    assign m_tuser = result.table_full;
    assign m_tlast = result.last_entry;

endmodule

[src/etbf_checker.sv]
// port level checks of the router and their binding
module etbf_checker import etbf_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an edge is in work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[2:0] == NODE_W'(NODES - 1))
        else $error("last result not on the final node");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("input taken before all results of an edge");

endmodule

bind edge_table_bellman_ford_router etbf_checker #(.NODES(NODES)) u_etbf_checker (.*);

[sim/testbench.sv]
// self-checking testbench for the edge table shortest path router
module testbench import etbf_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = NODES_DEF;
    localparam int E = EDGES_DEF;

    typedef struct {
        node_t             node;
        logic [DIST_W-1:0] dist_val;
        node_t             pred;
        logic              pred_ok;
        logic              full;
        logic              last;
    } route_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [NODE_W-1:0]     cfg_data = '0;

    node_t             tbl_from [E];
    node_t             tbl_to [E];
    logic [COST_W-1:0] tbl_cost [E];
    int                tbl_count = 0;
    bit                pair_used [N][N];
    node_t             src_node = '0;
    route_t            route_q [$];
    int                err_cnt = 0;
    int                rx_hold = 0;
    bit                tx_calm = 1'b0;
    bit                rx_calm = 1'b0;

    edge_table_bellman_ford_router u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic int pick_gap(int long_max);
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
        return $urandom_range(long_max / 4, long_max);
    endfunction

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 3))
            0: return COST_W'($urandom_range(0, 15));
            1: return $urandom_range(0, 1) ? {COST_W{1'b1}} : '0;
            default: return COST_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // update the edge table, rerun the path search and queue one route per node
    function automatic void predict_routes(node_t f, node_t t, logic [COST_W-1:0] w);
        int     best_dist [N];
        node_t  pred [N];
        bit     pred_ok [N];
        bit     hit;
        bit     full;
        int     cand;
        route_t r;
        hit = 1'b0;
        full = 1'b0;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_from[i] == f && tbl_to[i] == t) begin
                tbl_cost[i] = w;
                hit = 1'b1;
            end
        end
        if (!hit) begin
            if (tbl_count < E) begin
                tbl_from[tbl_count] = f;
                tbl_to[tbl_count] = t;
                tbl_cost[tbl_count] = w;
                tbl_count++;
                pair_used[f][t] = 1'b1;
            end else begin
                full = 1'b1;
            end
        end
        for (int i = 0; i < N; i++) begin
            best_dist[i] = UNREACH;
            pred[i] = '0;
            pred_ok[i] = 1'b0;
        end
        best_dist[src_node] = 0;
        for (int rnd = 1; rnd < N; rnd++) begin
            for (int j = 0; j < tbl_count; j++) begin
                if (best_dist[tbl_from[j]] == UNREACH) continue;
                cand = best_dist[tbl_from[j]] + tbl_cost[j];
                if (cand < best_dist[tbl_to[j]]) begin
                    best_dist[tbl_to[j]] = cand;
                    pred[tbl_to[j]] = tbl_from[j];
                    pred_ok[tbl_to[j]] = 1'b1;
                end
            end
        end
        for (int i = 0; i < N; i++) begin
            r.node = node_t'(i);
            r.dist_val = DIST_W'(best_dist[i]);
            r.pred = pred_ok[i] ? pred[i] : node_t'(0);
            r.pred_ok = pred_ok[i];
            r.full = full;
            r.last = (i == N - 1);
            route_q.insert(route_q.size(), r);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    task automatic check_route();
        route_t want;
        if (route_q.size() == 0) begin
            report_mismatch("result with nothing pending, node", m_tdata[2:0], -1);
            return;
        end
        want = route_q.pop_front();
        if (m_tdata[2:0] !== want.node) report_mismatch("node_index", m_tdata[2:0], want.node);
        if (m_tdata[16:3] !== want.dist_val)
            report_mismatch("distance", m_tdata[16:3], want.dist_val);
        if (m_tdata[19:17] !== want.pred) report_mismatch("pred_node", m_tdata[19:17], want.pred);
        if (m_tdata[20] !== want.pred_ok)
            report_mismatch("prev_valid", m_tdata[20], want.pred_ok);
        if (m_tdata[23:21] !== 3'b000) report_mismatch("tdata padding", m_tdata[23:21], 0);
        if (m_tuser !== want.full) report_mismatch("table_full", m_tuser, want.full);
        if (m_tlast !== want.last) report_mismatch("last_entry", m_tlast, want.last);
    endtask

    // result side: check each transfer and stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_route();
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            rx_hold <= pick_gap(60) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_edge(node_t f, node_t t, logic [COST_W-1:0] w);
        int gap;
        gap = tx_calm ? 1 : pick_gap(700);
        repeat (gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {w, t, f};
        do @(posedge aclk); while (!s_tready);
        predict_routes(f, t, w);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained(int tail);
        while (route_q.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic set_source(node_t n);
        wait_drained(4);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        do @(posedge aclk); while (!cfg_ready);
        src_node = n;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_first_edges();
        send_edge(3'd0, 3'd1, 10'd0);
        send_edge(3'd1, 3'd2, 10'd1023);
        send_edge(3'd2, 3'd3, 10'd5);
        send_edge(3'd3, 3'd3, 10'd7);
        send_edge(3'd4, 3'd0, 10'd3);
    endtask

    // existing edges keep their place; a tie does not replace the predecessor
    task automatic test_cost_update();
        send_edge(3'd1, 3'd2, 10'd10);
        send_edge(3'd0, 3'd2, 10'd1023);
        send_edge(3'd0, 3'd2, 10'd10);
        send_edge(3'd0, 3'd2, 10'd9);
    endtask

    // edges inserted against the path order need several rounds
    task automatic test_path_chain();
        send_edge(3'd6, 3'd7, 10'd1023);
        send_edge(3'd5, 3'd6, 10'd1023);
        send_edge(3'd4, 3'd5, 10'd1023);
        send_edge(3'd3, 3'd4, 10'd1023);
        send_edge(3'd7, 3'd6, 10'd1);
    endtask

    task automatic test_source_change();
        set_source(3'd7);
        send_edge(3'd7, 3'd0, 10'd2);
        set_source(3'd3);
        send_edge(3'd5, 3'd4, 10'd0);
        set_source(3'd0);
        send_edge(3'd2, 3'd1, 10'd512);
    endtask

    // mostly new edges until the table is full, then cost updates
    task automatic test_random_edges(int count);
        int free_pairs [$];
        int p;
        for (int k = 0; k < count; k++) begin
            if (k % 26 == 25) begin
                set_source(node_t'($urandom_range(0, N - 1)));
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            free_pairs = {};
            for (int q = 0; q < N * N; q++) begin
                if (!pair_used[q / N][q % N]) free_pairs.insert(free_pairs.size(), q);
            end
            if (free_pairs.size() != 0 && $urandom_range(0, 3) != 0)
                p = free_pairs[$urandom_range(0, free_pairs.size() - 1)];
            else
                p = $urandom_range(0, N * N - 1);
            send_edge(node_t'(p / N), node_t'(p % N), pick_cost());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_edges();
        test_cost_update();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        test_path_chain();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        test_source_change();
        test_random_edges(113);
        wait_drained(40);
        if (err_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
